/* hdl/fbpa_pkg.sv */
// Shared types and constants for the fixed block pool allocator.
// Used by fbpa_ctrl, fbpa_dp and fixed_block_pool_allocator; depends on nothing.
package fbpa_pkg;

  // Number of slots in the pool and the widths that follow from it.
  localparam int SLOTS = 64;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int PROD_W = SLOT_W + 16;

  // Field and register widths.
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int COUNT_W = 7;
  localparam int SLOT_IDX_W = 6;
  localparam int CFG_IDX_W = 2;

  // Restoring divider: one quotient bit per step.
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd2;

  typedef enum logic [2:0] {
    STATUS_ALLOCATED = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_FREED     = 3'd2,
    STATUS_DOUBLE    = 3'd3,
    STATUS_INVALID   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_MUL,
    FSM_DIV,
    FSM_LOOK,
    FSM_UPD,
    FSM_EMIT
  } fsm_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;
    logic    scan_next;
    logic    alloc_mark;
    logic    div_step;
    logic    slot_load;
    logic    free_mark;
    logic    mul_load;
    logic    res_load;
    status_t res_code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
    logic scan_hit;
    logic div_last;
    logic bad;
    logic slot_free;
  } stat_t;

endpackage

/* hdl/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator: controller plus datapath.
// Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
//
//   Channel  Handshake              Payload
//   req      req_valid/req_ready    mode, address
//   rsp      rsp_valid/rsp_ready    status, block_address, slot_num
//   cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An allocate scans the slots, one slot per cycle, from slot 0 up to the effective slot
// count; the lowest free slot is marked in use and its block address multiplied out
// before the result register is loaded, or the pool is reported full. A free runs the
// 32-step restoring divider that turns the address offset into a slot number, then
// checks the slot number and, if it is valid, updates the free map. The controller is
// idle again as the result is loaded, so the next request can be accepted in the following cycle at the earliest.
// Synchronous reset marks every slot free and loads the register defaults.
// One transaction is worked on at a time; a finished result waits in the output
// register while the next request is accepted, and a stalled response holds the
// controller only when a second result is ready to be written.
module fixed_block_pool_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic                                 mode,
  input  logic [fbpa_pkg::ADDR_W-1:0]          address,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output logic [2:0]                           status,
  output logic [fbpa_pkg::ADDR_W-1:0]          block_address,
  output logic [fbpa_pkg::SLOT_IDX_W-1:0]      slot_num,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]          cfg_data
);

  fbpa_pkg::cmd_t  cmd;
  fbpa_pkg::stat_t stat;

  // Configuration writes are registered directly, so the port is always ready.
  // Writes to an index beyond the register list are dropped by the datapath.
  assign cfg_ready = 1'b1;

  // The controller sequences the scan, the division and the result hand-off.
  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_mode  (mode),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // The datapath holds the configuration, the free map and the arithmetic.
  fbpa_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .req_address       (address),
    .cmd               (cmd),
    .stat              (stat),
    .rsp_status        (status),
    .rsp_block_address (block_address),
    .rsp_slot_num      (slot_num)
  );

endmodule

/* hdl/fbpa_ctrl.sv */
// Controller state machine of the fixed block pool allocator.
// Depends on fbpa_pkg; drives the datapath fbpa_dp through cmd_t and reads stat_t.
module fbpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic            req_mode,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output fbpa_pkg::cmd_t  cmd,
  input  fbpa_pkg::stat_t stat
);

  fbpa_pkg::fsm_t    state;
  fbpa_pkg::fsm_t    state_next;
  fbpa_pkg::status_t res_code;
  fbpa_pkg::status_t res_code_next;
  logic              out_free;
  logic              rsp_valid_next;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fbpa_pkg::FSM_IDLE;
      res_code  <= fbpa_pkg::STATUS_FULL;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_code  <= res_code_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Next state and the status code that the result will carry.
  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    case (state)
      fbpa_pkg::FSM_IDLE: begin
        if (req_valid) begin
          state_next = req_mode ? fbpa_pkg::FSM_DIV : fbpa_pkg::FSM_SCAN;
        end
      end
      fbpa_pkg::FSM_SCAN: begin
        if (stat.scan_end) begin
          res_code_next = fbpa_pkg::STATUS_FULL;
          state_next    = fbpa_pkg::FSM_EMIT;
        end else if (stat.scan_hit) begin
          state_next = fbpa_pkg::FSM_MUL;
        end
      end
      fbpa_pkg::FSM_MUL: begin
        res_code_next = fbpa_pkg::STATUS_ALLOCATED;
        state_next    = fbpa_pkg::FSM_EMIT;
      end
      fbpa_pkg::FSM_DIV: begin
        if (stat.div_last) begin
          state_next = fbpa_pkg::FSM_LOOK;
        end
      end
      fbpa_pkg::FSM_LOOK: begin
        if (stat.bad) begin
          res_code_next = fbpa_pkg::STATUS_INVALID;
          state_next    = fbpa_pkg::FSM_EMIT;
        end else begin
          state_next = fbpa_pkg::FSM_UPD;
        end
      end
      fbpa_pkg::FSM_UPD: begin
        res_code_next = stat.slot_free ? fbpa_pkg::STATUS_DOUBLE : fbpa_pkg::STATUS_FREED;
        state_next    = fbpa_pkg::FSM_EMIT;
      end
      fbpa_pkg::FSM_EMIT: begin
        if (out_free) begin
          state_next = fbpa_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = fbpa_pkg::FSM_IDLE;
      end
    endcase
  end

  // Commands for the current state.
  always_comb begin
    req_ready      = 1'b0;
    cmd            = '0;
    cmd.res_code   = res_code;
    case (state)
      fbpa_pkg::FSM_IDLE: begin
        req_ready = 1'b1;
        cmd.start = req_valid;
      end
      fbpa_pkg::FSM_SCAN: begin
        cmd.scan_next  = !stat.scan_end && !stat.scan_hit;
        cmd.alloc_mark = !stat.scan_end && stat.scan_hit;
      end
      fbpa_pkg::FSM_MUL: begin
        cmd.mul_load = 1'b1;
      end
      fbpa_pkg::FSM_DIV: begin
        cmd.div_step = 1'b1;
      end
      fbpa_pkg::FSM_LOOK: begin
        cmd.slot_load = 1'b1;
      end
      fbpa_pkg::FSM_UPD: begin
        cmd.free_mark = !stat.slot_free;
      end
      fbpa_pkg::FSM_EMIT: begin
        cmd.res_load = out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

/* hdl/fbpa_dp.sv */
// Datapath of the fixed block pool allocator: configuration, free map, slot
// counter, restoring divider, slot multiplier and result register. Depends on fbpa_pkg.
module fbpa_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]          cfg_data,
  input  logic [fbpa_pkg::ADDR_W-1:0]          req_address,
  input  fbpa_pkg::cmd_t                       cmd,
  output fbpa_pkg::stat_t                      stat,
  output logic [2:0]                           rsp_status,
  output logic [fbpa_pkg::ADDR_W-1:0]          rsp_block_address,
  output logic [fbpa_pkg::SLOT_IDX_W-1:0]      rsp_slot_num
);

  logic [fbpa_pkg::ADDR_W-1:0]    base_address;
  logic [fbpa_pkg::SIZE_W-1:0]    block_size;
  logic [fbpa_pkg::COUNT_W-1:0]   slot_count;
  logic [fbpa_pkg::SLOTS-1:0]     free_map;

  logic [fbpa_pkg::CNT_W-1:0]     slot;
  logic [fbpa_pkg::CNT_W-1:0]     eff_count;
  logic [fbpa_pkg::SLOT_W-1:0]    slot_sel;
  logic [fbpa_pkg::ADDR_W-1:0]    slot_wide;

  logic [fbpa_pkg::ADDR_W-1:0]    quo;
  logic [fbpa_pkg::SIZE_W-1:0]    rem;
  logic [fbpa_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                           pre_bad;
  logic [fbpa_pkg::SIZE_W:0]      rem_sh;
  logic [fbpa_pkg::SIZE_W:0]      rem_diff;
  logic                           rem_ge;

  logic [fbpa_pkg::PROD_W-1:0]    mul_full;
  logic [fbpa_pkg::ADDR_W-1:0]    prod;

  // Slot count is clamped to the pool size.
  always_comb begin
    if ({{(32 - fbpa_pkg::COUNT_W){1'b0}}, slot_count} > 32'(fbpa_pkg::SLOTS)) begin
      eff_count = fbpa_pkg::CNT_W'(fbpa_pkg::SLOTS);
    end else begin
      eff_count = fbpa_pkg::CNT_W'(slot_count);
    end
  end

  assign slot_sel  = slot[fbpa_pkg::SLOT_W-1:0];
  assign slot_wide = {{(fbpa_pkg::ADDR_W - fbpa_pkg::CNT_W){1'b0}}, slot};

  // One restoring division step.
  assign rem_sh   = {rem, quo[fbpa_pkg::ADDR_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, block_size};
  assign rem_diff = rem_sh - {1'b0, block_size};

  assign mul_full = fbpa_pkg::PROD_W'(slot_sel) * fbpa_pkg::PROD_W'(block_size);

  assign stat.scan_end  = slot >= eff_count;
  assign stat.scan_hit  = free_map[slot_sel];
  assign stat.slot_free = free_map[slot_sel];
  assign stat.div_last  = div_cnt == fbpa_pkg::DIV_CNT_W'(fbpa_pkg::DIV_STEPS - 1);
  assign stat.bad       = pre_bad || (rem != '0) ||
                          (quo >= {{(fbpa_pkg::ADDR_W - fbpa_pkg::CNT_W){1'b0}}, eff_count});

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      block_size   <= 16'd16;
      slot_count   <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        fbpa_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data;
        fbpa_pkg::CFG_BLOCK_SIZE:   block_size   <= cfg_data[fbpa_pkg::SIZE_W-1:0];
        fbpa_pkg::CFG_SLOT_COUNT:   slot_count   <= cfg_data[fbpa_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_map <= '1;
    end else if (cmd.alloc_mark) begin
      free_map[slot_sel] <= 1'b0;
    end else if (cmd.free_mark) begin
      free_map[slot_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      slot <= '0;
    end else if (cmd.scan_next) begin
      slot <= slot + fbpa_pkg::CNT_W'(1);
    end else if (cmd.slot_load) begin
      slot <= quo[fbpa_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo     <= req_address - base_address;
      rem     <= '0;
      div_cnt <= '0;
      pre_bad <= (req_address < base_address) || (block_size == '0);
    end else if (cmd.div_step) begin
      quo     <= {quo[fbpa_pkg::ADDR_W-2:0], rem_ge};
      rem     <= rem_ge ? rem_diff[fbpa_pkg::SIZE_W-1:0] : rem_sh[fbpa_pkg::SIZE_W-1:0];
      div_cnt <= div_cnt + fbpa_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= {{(fbpa_pkg::ADDR_W - fbpa_pkg::PROD_W){1'b0}}, mul_full};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_status <= cmd.res_code;
      if (cmd.res_code == fbpa_pkg::STATUS_ALLOCATED) begin
        rsp_block_address <= base_address + prod;
      end else begin
        rsp_block_address <= '0;
      end
      if (cmd.res_code == fbpa_pkg::STATUS_ALLOCATED ||
          cmd.res_code == fbpa_pkg::STATUS_FREED ||
          cmd.res_code == fbpa_pkg::STATUS_DOUBLE) begin
        rsp_slot_num <= slot_wide[fbpa_pkg::SLOT_IDX_W-1:0];
      end else begin
        rsp_slot_num <= '0;
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for fixed_block_pool_allocator: a directed table, then random phases.
// Depends on fbpa_pkg and the fixed_block_pool_allocator RTL; reads no files.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  // A watchdog ends the run when no transaction of any channel completes for this many cycles.
  // The slowest legal gap is a full-pool scan behind the long response hold-off below,
  // plus a sender burst, so this leaves a wide margin.
  localparam int STALL_LIMIT = 4000;
  // Cycles to keep watching for stray responses once every expected one has arrived.
  localparam int TAIL_CYCLES = 100;
  // Length of the one long stretch in which the receiver refuses responses.
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 13;
  localparam int PHASE_ITEMS = 125;

  // Register index 3 lies beyond the register list, so writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  typedef struct packed {
    status_t                 st;
    logic [ADDR_W-1:0]       blk;
    logic [SLOT_IDX_W-1:0]   slot;
  } pool_reply_t;

  localparam pool_reply_t INVALID_REPLY = '{STATUS_INVALID, 32'h0, 6'd0};
  localparam pool_reply_t FULL_REPLY = '{STATUS_FULL, 32'h0, 6'd0};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One row of the directed table. For request rows, value is the address; for register
  // rows it is the write data. A row with typed set carries its expected reply, which
  // replaces the predicted one; other rows (and register rows) leave the reply unused.
  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic                    req_mode;
    logic [ADDR_W-1:0]       value;
    logic                    typed;
    pool_reply_t             reply;
  } dir_row_t;

  localparam dir_row_t DIRECTED [0:27] = '{
    // Fresh pool with base 0 and 16-byte blocks: allocation hands out the lowest slots, and
    // the address bits are ignored for an allocate.
    '{ROW_REQ, CFG_UNMAPPED, MODE_ALLOC, 32'hFFFFFFFF, 1'b1, '{STATUS_ALLOCATED, 32'h0, 6'd0}},
    '{ROW_REQ, CFG_UNMAPPED, MODE_ALLOC, 32'h0, 1'b1, '{STATUS_ALLOCATED, 32'h10, 6'd1}},
    // Free, then free again: the second one is a double free and the slot stays free.
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'h10, 1'b1, '{STATUS_FREED, 32'h0, 6'd1}},
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'h10, 1'b1, '{STATUS_DOUBLE, 32'h0, 6'd1}},
    // Offsets that are not whole blocks are rejected.
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'h11, 1'b1, INVALID_REPLY},
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'hFFFFFFFF, 1'b1, INVALID_REPLY},
    // The last slot is in range (never allocated, so a double free); one past it is not.
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'h3F0, 1'b1, '{STATUS_DOUBLE, 32'h0, 6'd63}},
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'h400, 1'b1, INVALID_REPLY},
    // Address zero is an ordinary address: here it names slot 0.
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'h0, 1'b1, '{STATUS_FREED, 32'h0, 6'd0}},
    // Top-of-memory base, largest block size, and a one-slot pool. The data words carry
    // junk above the register widths, which must be dropped.
    '{ROW_CFG, CFG_BASE_ADDRESS, MODE_ALLOC, 32'hFFFFFFF0, 1'b0, INVALID_REPLY},
    '{ROW_CFG, CFG_BLOCK_SIZE, MODE_ALLOC, 32'hFFFFFFFF, 1'b0, INVALID_REPLY},
    '{ROW_CFG, CFG_SLOT_COUNT, MODE_ALLOC, 32'hFFFFFF81, 1'b0, INVALID_REPLY},
    '{ROW_REQ, CFG_UNMAPPED, MODE_ALLOC, 32'h0, 1'b1, '{STATUS_ALLOCATED, 32'hFFFFFFF0, 6'd0}},
    '{ROW_REQ, CFG_UNMAPPED, MODE_ALLOC, 32'h0, 1'b1, FULL_REPLY},
    // Below the base is invalid; the base itself names slot 0.
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'h0, 1'b1, INVALID_REPLY},
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'hFFFFFFF0, 1'b1, '{STATUS_FREED, 32'h0, 6'd0}},
    // Zero block size and zero slots: allocate is full, free is invalid.
    '{ROW_CFG, CFG_BLOCK_SIZE, MODE_ALLOC, 32'h5A5A0000, 1'b0, INVALID_REPLY},
    '{ROW_CFG, CFG_SLOT_COUNT, MODE_ALLOC, 32'h0, 1'b0, INVALID_REPLY},
    '{ROW_REQ, CFG_UNMAPPED, MODE_ALLOC, 32'h0, 1'b1, FULL_REPLY},
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'hFFFFFFF0, 1'b1, INVALID_REPLY},
    // A slot count above the pool size is clipped to the pool; the unmapped index is a no-op.
    '{ROW_CFG, CFG_SLOT_COUNT, MODE_ALLOC, 32'h7F, 1'b0, INVALID_REPLY},
    '{ROW_CFG, CFG_UNMAPPED, MODE_ALLOC, 32'hFFFFFFFF, 1'b0, INVALID_REPLY},
    // With a zero block size every allocation lands on the base address.
    '{ROW_REQ, CFG_UNMAPPED, MODE_ALLOC, 32'h0, 1'b1, '{STATUS_ALLOCATED, 32'hFFFFFFF0, 6'd0}},
    '{ROW_REQ, CFG_UNMAPPED, MODE_ALLOC, 32'h0, 1'b1, '{STATUS_ALLOCATED, 32'hFFFFFFF0, 6'd1}},
    // Reconfiguring keeps the free map: slot 1 is still in use and can be freed.
    '{ROW_CFG, CFG_BASE_ADDRESS, MODE_ALLOC, 32'h10, 1'b0, INVALID_REPLY},
    '{ROW_CFG, CFG_BLOCK_SIZE, MODE_ALLOC, 32'h10, 1'b0, INVALID_REPLY},
    '{ROW_REQ, CFG_UNMAPPED, MODE_FREE, 32'h20, 1'b0, INVALID_REPLY},
    '{ROW_REQ, CFG_UNMAPPED, MODE_ALLOC, 32'h0, 1'b0, INVALID_REPLY}
  };

  logic                    clk;
  logic                    rst;
  logic                    req_valid;
  logic                    req_ready;
  logic                    mode;
  logic [ADDR_W-1:0]       address;
  logic                    rsp_valid;
  logic                    rsp_ready;
  logic [2:0]              status;
  logic [ADDR_W-1:0]       block_address;
  logic [SLOT_IDX_W-1:0]   slot_num;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [ADDR_W-1:0]       cfg_data;

  // Expected-reply override that travels with each request, plus the idling controls.
  logic                    row_typed;
  pool_reply_t             row_reply;
  logic                    no_idle;
  logic                    hold_replies;

  // Shadow copy of the pool: registers and one free bit per slot.
  logic [ADDR_W-1:0]       pool_base;
  logic [SIZE_W-1:0]       pool_block_size;
  logic [COUNT_W-1:0]      pool_slots_cfg;
  logic [SLOTS-1:0]        slot_is_free;

  pool_reply_t             awaited_replies[$];
  int unsigned             failures = 0;

  fixed_block_pool_allocator i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Works out the reply to one request and updates the shadow free map the way the pool
  // does. Slots above the effective count keep their bits but are not looked at.
  function automatic pool_reply_t predict_pool_reply(input logic req_mode,
                                                     input logic [ADDR_W-1:0] addr);
    pool_reply_t       r;
    int unsigned       lim;
    int unsigned       k;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] slot;
    r = INVALID_REPLY;
    lim = (pool_slots_cfg > SLOTS) ? SLOTS : pool_slots_cfg;
    if (req_mode == MODE_ALLOC) begin
      r = FULL_REPLY;
      for (k = 0; k < lim; k++) begin
        if (slot_is_free[k]) begin
          slot_is_free[k] = 1'b0;
          r.st = STATUS_ALLOCATED;
          r.blk = pool_base + ADDR_W'(k) * ADDR_W'(pool_block_size);
          r.slot = SLOT_IDX_W'(k);
          break;
        end
      end
    end else if (addr >= pool_base && pool_block_size != 0) begin
      offset = addr - pool_base;
      slot = offset / ADDR_W'(pool_block_size);
      if (offset % ADDR_W'(pool_block_size) == 0 && slot < lim) begin
        r.slot = SLOT_IDX_W'(slot);
        if (slot_is_free[slot]) begin
          r.st = STATUS_DOUBLE;
        end else begin
          slot_is_free[slot] = 1'b1;
          r.st = STATUS_FREED;
        end
      end
    end
    return r;
  endfunction

  // Everything is sampled at the rising edge, before the edge's nonblocking updates land,
  // so the shadow sees exactly what the block sees. Register writes update the shadow,
  // accepted requests push their reply, and accepted responses are checked in order.
  always @(posedge clk) begin : scoreboard
    pool_reply_t want;
    if (rst) begin
      pool_base = '0;
      pool_block_size = 16'd16;
      pool_slots_cfg = 7'd64;
      slot_is_free = '1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_ADDRESS: pool_base = cfg_data;
          CFG_BLOCK_SIZE:   pool_block_size = cfg_data[SIZE_W-1:0];
          CFG_SLOT_COUNT:   pool_slots_cfg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        want = predict_pool_reply(mode, address);
        awaited_replies.push_back(row_typed ? row_reply : want);
      end
      if (rsp_valid && rsp_ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t ns: unexpected response status %0d address %h slot %0d",
                   $time, status, block_address, slot_num);
          failures++;
        end else begin
          want = awaited_replies.pop_front();
          if (status !== want.st) begin
            $display("%0t ns: status expected %0d, got %0d", $time, want.st, status);
            failures++;
          end
          if (block_address !== want.blk) begin
            $display("%0t ns: block_address expected %h, got %h",
                     $time, want.blk, block_address);
            failures++;
          end
          if (slot_num !== want.slot) begin
            $display("%0t ns: slot_num expected %0d, got %0d", $time, want.slot, slot_num);
            failures++;
          end
        end
      end
    end
  end

  // The receiver mixes short refusals with ready stretches of varying length. Once asked,
  // it refuses for a long stretch so the block backs up into its request channel.
  initial begin : receiver
    rsp_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_replies) begin
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_replies = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  // Offers one request and returns at the edge where it is accepted. Valid stays high
  // into the next request unless a random gap is inserted first.
  task automatic offer_request(input logic m, input logic [ADDR_W-1:0] a,
                               input logic typed, input pool_reply_t r);
    cfg_valid <= 1'b0;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode <= m;
    address <= a;
    row_typed <= typed;
    row_reply <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stops offering and waits until every expected reply has come back. The queue is
  // looked at on falling edges, where the scoreboard has settled.
  task automatic drain_replies();
    req_valid <= 1'b0;
    @(negedge clk);
    while (awaited_replies.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Writes one register and returns at the accepting edge with valid still high, so
  // back-to-back writes need no gap; the next request lowers it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t             row;
    bit                   after_cfg;
    int                   n;
    int unsigned          phase;
    int unsigned          k;
    int unsigned          pick;
    int unsigned          lim;
    int unsigned          slot;
    int unsigned          alloc_pct;
    logic [ADDR_W-1:0]    base;
    logic [ADDR_W-1:0]    addr;
    logic [ADDR_W-1:0]    cfg_word;
    logic [SIZE_W-1:0]    blk_size;
    logic [COUNT_W-1:0]   slots_cfg;

    rst = 1'b1;
    req_valid = 1'b0;
    mode = MODE_ALLOC;
    address = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BASE_ADDRESS;
    cfg_data = '0;
    row_typed = 1'b0;
    row_reply = INVALID_REPLY;
    no_idle = 1'b0;
    hold_replies = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Register rows wait for the block to go idle, except when they
    // follow another register row.
    after_cfg = 1'b0;
    for (n = 0; n < $size(DIRECTED); n++) begin
      row = DIRECTED[n];
      if (row.kind == ROW_CFG) begin
        if (!after_cfg) drain_replies();
        write_register(row.reg_idx, row.value);
      end else begin
        offer_request(row.req_mode, row.value, row.typed, row.reply);
      end
      after_cfg = (row.kind == ROW_CFG);
    end

    // Random phases. Each starts idle with a fresh setting of every register; the early
    // ones pin the extremes, the rest are drawn at random with mostly small pools so that
    // the pool fills and empties often. The last phase runs without any idling.
    for (phase = 0; phase < PHASES; phase++) begin
      drain_replies();
      no_idle = (phase == PHASES - 1);
      alloc_pct = 45;
      base = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'hFFFFF);
      case ($urandom_range(0, 3))
        0:       blk_size = 16'd1;
        1:       blk_size = 16'd16;
        2:       blk_size = 16'hFFFF;
        default: blk_size = SIZE_W'($urandom_range(2, 4096));
      endcase
      slots_cfg = COUNT_W'($urandom_range(1, 12));
      case (phase)
        0: begin
          base = '0;
          blk_size = 16'd1;
          slots_cfg = 7'd8;
        end
        1: begin
          // Top base with the largest blocks wraps every address past slot 0; allocate
          // heavily so the whole pool, up to the last slot, gets handed out.
          base = '1;
          blk_size = 16'hFFFF;
          slots_cfg = 7'h7F;
          alloc_pct = 85;
        end
        2: begin
          slots_cfg = 7'd64;
          blk_size = 16'd16;
          alloc_pct = 30;
        end
        3: begin
          blk_size = '0;
          slots_cfg = 7'd64;
        end
        4: slots_cfg = '0;
        6: slots_cfg = 7'd100;
        default: ;
      endcase
      lim = (slots_cfg > SLOTS) ? SLOTS : slots_cfg;

      write_register(CFG_BASE_ADDRESS, base);
      cfg_word = $urandom();
      cfg_word[SIZE_W-1:0] = blk_size;
      write_register(CFG_BLOCK_SIZE, cfg_word);
      cfg_word = $urandom();
      cfg_word[COUNT_W-1:0] = slots_cfg;
      write_register(CFG_SLOT_COUNT, cfg_word);
      write_register(CFG_UNMAPPED, $urandom());

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Back the block up once against a refusing receiver, and once let it run dry
        // in the middle of a phase.
        if (phase == 5 && k == 20) hold_replies = 1'b1;
        if (phase == 7 && k == 60) drain_replies();
        slot = $urandom_range(0, lim);
        addr = base + ADDR_W'(slot) * ADDR_W'(blk_size);
        if ($urandom_range(0, 99) < alloc_pct) begin
          offer_request(MODE_ALLOC, $urandom(), 1'b0, INVALID_REPLY);
        end else begin
          // Mostly well-formed frees (one slot past the end included), then misaligned,
          // below-base and fully random addresses.
          pick = $urandom_range(0, 99);
          if (pick >= 88)
            addr = $urandom();
          else if (pick >= 77)
            addr = base - ADDR_W'($urandom_range(1, 4096));
          else if (pick >= 65)
            addr = (blk_size > 1) ? addr + ADDR_W'($urandom_range(1, blk_size - 1))
                                  : $urandom();
          offer_request(MODE_FREE, addr, 1'b0, INVALID_REPLY);
        end
      end
    end

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
hdl/fbpa_pkg.sv
hdl/fbpa_ctrl.sv
hdl/fbpa_dp.sv
hdl/fixed_block_pool_allocator.sv
tb/sv/tb.sv
